// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the anchor list table engine.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ASSERT_IMPLY check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ASSERT_NEXT check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/alte_pkg.sv
// Types and codes of the anchor list table engine: request and response words.
// Depends on nothing.
package alte_pkg;

   localparam int DEF_MAX_ENTRIES = 8;

   localparam logic [2:0] REQ_LOAD       = 3'd0;
   localparam logic [2:0] REQ_REMOVE     = 3'd1;
   localparam logic [2:0] REQ_RECORD     = 3'd2;
   localparam logic [2:0] REQ_INVALIDATE = 3'd3;
   localparam logic [2:0] REQ_DUMP       = 3'd4;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_TOO_LONG  = 3'd1;
   localparam logic [2:0] STS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STS_BAD_SLOT  = 3'd3;
   localparam logic [2:0] STS_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [15:0]        beacon_id;
      logic               last_in_list;
      logic [2:0]         slot;
      logic signed [31:0] distance_in;
      logic               distance_ok;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        entry_id;
      logic signed [31:0] entry_distance;
      logic               entry_valid;
      logic [3:0]         entry_count;
      logic               last_result;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]        id;
      logic signed [31:0] distance;
      logic               valid;
   } entry_type;

endpackage

// File: rtl/anchor_list_table_engine_top.sv
// Anchor list table engine: table of anchor IDs with distances, list reload,
// remove, record, invalidate and dump. Depends on alte_pkg and assert_macros.svh.
//
//   channel   ports                      handshake
//   request   start, busy, req_word      taken at an edge with start high, busy low
//   response  rsp_strobe, rsp_word       one-cycle strobe per word, cannot be held off
//
// A load that is not the last ID, an unknown request, a dropped list, a bad
// slot and an empty dump answer straight from idle. Other requests go through
// the single read port of the entry memory, one read per visited entry: a
// remove compares entries until the ID matches, then shifts later ones down; a
// dump outputs each entry; a list reload compares each new ID against the table.
// Synchronous reset empties the table and the pending list; no clearing pass.
// busy stays high until the last response word of an item has been issued.
`include "assert_macros.svh"
module anchor_list_table_engine_top #(
   parameter int MAX_ENTRIES = alte_pkg::DEF_MAX_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  alte_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output alte_pkg::rsp_word_type rsp_word
);
   import alte_pkg::*;

   localparam int CW        = $clog2(MAX_ENTRIES + 1);
   localparam int IW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int AW        = IW + 1;
   localparam int SW        = (CW > 3) ? CW : 3;
   localparam int MEM_DEPTH = 2 * (1 << IW);
   localparam int PEND_DEPTH = 1 << IW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AP_RDP, ST_AP_ID, ST_AP_RD, ST_AP_CMP,
      ST_RM_RD, ST_RM_CMP, ST_SH_RD, ST_SH_WR,
      ST_RC_RD, ST_RC_WR, ST_IV_RD, ST_IV_WR, ST_DU_RD, ST_DU_OUT
   } state_type;

   state_type    state_ff, state_in;
   logic         bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pcount_ff, pcount_in;
   logic         povf_ff, povf_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [15:0]  cur_id_ff, cur_id_in;
   req_word_type req_ff, req_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   entry_type    ent_mem [MEM_DEPTH];
   entry_type    ent_rd_ff;
   logic         ent_re, ent_we;
   logic [AW-1:0] ent_raddr, ent_waddr;
   entry_type    ent_wdata;

   logic [15:0]  pend_mem [PEND_DEPTH];
   logic [15:0]  pend_rd_ff;
   logic         pend_re, pend_we;
   logic [IW-1:0] pend_raddr, pend_waddr;

   logic [CW-1:0] i_inc;
   logic [CW-1:0] j_inc;
   logic         pend_full;
   logic         slot_ok;

   assign i_inc     = i_ff + CW'(1);
   assign j_inc     = j_ff + CW'(1);
   assign pend_full = (pcount_ff == CW'(MAX_ENTRIES));
   assign slot_ok   = (SW'(req_word.slot) < SW'(count_ff));

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= req_word.beacon_id;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[pend_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      count_in      = count_ff;
      pcount_in     = pcount_ff;
      povf_in       = povf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cur_id_in     = cur_id_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ent_re        = 1'b0;
      ent_we        = 1'b0;
      ent_raddr     = {bank_ff, j_ff[IW-1:0]};
      ent_waddr     = {bank_ff, i_ff[IW-1:0]};
      ent_wdata     = ent_rd_ff;
      pend_re       = 1'b0;
      pend_we       = 1'b0;
      pend_raddr    = i_ff[IW-1:0];
      pend_waddr    = pcount_ff[IW-1:0];

      rsp_word_in.status         = STS_OK;
      rsp_word_in.entry_id       = '0;
      rsp_word_in.entry_distance = '0;
      rsp_word_in.entry_valid    = 1'b0;
      rsp_word_in.entry_count    = 4'(count_ff);
      rsp_word_in.last_result    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_word;
               unique case (req_word.req_type)
                  REQ_LOAD: begin
                     if (!pend_full) begin
                        pend_we   = 1'b1;
                        pcount_in = pcount_ff + CW'(1);
                     end else begin
                        povf_in = 1'b1;
                     end
                     if (req_word.last_in_list && (povf_ff || pend_full)) begin
                        pcount_in          = '0;
                        povf_in            = 1'b0;
                        rsp_strobe_in      = 1'b1;
                        rsp_word_in.status = STS_TOO_LONG;
                     end else if (req_word.last_in_list) begin
                        i_in     = '0;
                        state_in = ST_AP_RDP;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     j_in     = '0;
                     state_in = ST_RM_RD;
                  end
                  REQ_RECORD: begin
                     if (slot_ok) begin
                        i_in     = CW'(req_word.slot);
                        state_in = ST_RC_RD;
                     end else begin
                        rsp_strobe_in      = 1'b1;
                        rsp_word_in.status = STS_BAD_SLOT;
                     end
                  end
                  REQ_INVALIDATE: begin
                     if (slot_ok) begin
                        i_in     = CW'(req_word.slot);
                        state_in = ST_IV_RD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_word_in.status = STS_EMPTY;
                     end else begin
                        i_in     = '0;
                        state_in = ST_DU_RD;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_AP_RDP: begin
            pend_re  = 1'b1;
            state_in = ST_AP_ID;
         end
         ST_AP_ID: begin
            cur_id_in = pend_rd_ff;
            j_in      = '0;
            state_in  = ST_AP_RD;
         end
         ST_AP_RD, ST_AP_CMP: begin
            ent_waddr          = {~bank_ff, i_ff[IW-1:0]};
            ent_wdata.id       = cur_id_ff;
            ent_wdata.distance = '0;
            ent_wdata.valid    = 1'b0;
            if (state_ff == ST_AP_RD && j_ff < count_ff) begin
               ent_re   = 1'b1;
               state_in = ST_AP_CMP;
            end else if (state_ff == ST_AP_CMP && ent_rd_ff.id != cur_id_ff) begin
               j_in     = j_inc;
               state_in = ST_AP_RD;
            end else begin
               if (state_ff == ST_AP_CMP) begin
                  ent_wdata.distance = ent_rd_ff.distance;
                  ent_wdata.valid    = ent_rd_ff.valid;
               end
               ent_we = 1'b1;
               i_in   = i_inc;
               if (i_inc == pcount_ff) begin
                  bank_in                 = ~bank_ff;
                  count_in                = pcount_ff;
                  pcount_in               = '0;
                  povf_in                 = 1'b0;
                  rsp_strobe_in           = 1'b1;
                  rsp_word_in.entry_count = 4'(pcount_ff);
                  state_in                = ST_IDLE;
               end else begin
                  state_in = ST_AP_RDP;
               end
            end
         end
         ST_RM_RD: begin
            if (j_ff < count_ff) begin
               ent_re   = 1'b1;
               state_in = ST_RM_CMP;
            end else begin
               rsp_strobe_in      = 1'b1;
               rsp_word_in.status = STS_NOT_FOUND;
               state_in           = ST_IDLE;
            end
         end
         ST_RM_CMP: begin
            if (ent_rd_ff.id == req_ff.beacon_id) begin
               i_in     = j_ff;
               state_in = ST_SH_RD;
            end else begin
               j_in     = j_inc;
               state_in = ST_RM_RD;
            end
         end
         ST_SH_RD: begin
            ent_raddr = {bank_ff, i_inc[IW-1:0]};
            if (i_inc < count_ff) begin
               ent_re   = 1'b1;
               state_in = ST_SH_WR;
            end else begin
               count_in                = count_ff - CW'(1);
               rsp_strobe_in           = 1'b1;
               rsp_word_in.entry_count = 4'(count_ff - CW'(1));
               state_in                = ST_IDLE;
            end
         end
         ST_SH_WR: begin
            ent_we   = 1'b1;
            i_in     = i_inc;
            state_in = ST_SH_RD;
         end
         ST_RC_RD: begin
            ent_raddr = {bank_ff, i_ff[IW-1:0]};
            ent_re    = 1'b1;
            state_in  = ST_RC_WR;
         end
         ST_RC_WR: begin
            ent_wdata.distance = req_ff.distance_in;
            ent_wdata.valid    = req_ff.distance_ok;
            ent_we             = 1'b1;
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_IV_RD: begin
            ent_raddr = {bank_ff, i_ff[IW-1:0]};
            if (i_ff < count_ff) begin
               ent_re   = 1'b1;
               state_in = ST_IV_WR;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IV_WR: begin
            ent_wdata.valid = 1'b0;
            ent_we          = 1'b1;
            i_in            = i_inc;
            state_in        = ST_IV_RD;
         end
         ST_DU_RD: begin
            ent_raddr = {bank_ff, i_ff[IW-1:0]};
            ent_re    = 1'b1;
            state_in  = ST_DU_OUT;
         end
         ST_DU_OUT: begin
            rsp_strobe_in              = 1'b1;
            rsp_word_in.entry_id       = ent_rd_ff.id;
            rsp_word_in.entry_distance = ent_rd_ff.distance;
            rsp_word_in.entry_valid    = ent_rd_ff.valid;
            rsp_word_in.last_result    = (i_inc == count_ff);
            i_in                       = i_inc;
            state_in                   = (i_inc == count_ff) ? ST_IDLE : ST_DU_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         count_ff      <= '0;
         pcount_ff     <= '0;
         povf_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         count_ff      <= count_in;
         pcount_ff     <= pcount_in;
         povf_ff       <= povf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_id_ff   <= cur_id_in;
      req_ff      <= req_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `ASSERT_NEXT(a_start_acts, clock, reset, start && !busy, busy || rsp_strobe)
   `ASSERT_IMPLY(a_last_frees, clock, reset, rsp_strobe && rsp_word.last_result, !busy)
   `ASSERT_IMPLY(a_more_holds, clock, reset, rsp_strobe && !rsp_word.last_result, busy)
   `ASSERT_IMPLY(a_counts_fit, clock, reset, 1'b1, count_ff <= CW'(MAX_ENTRIES) && pcount_ff <= CW'(MAX_ENTRIES))

endmodule
